// ===== sv/sorted_list_insert_range_delete_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted list unit assertion macros
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_RANGE_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_RANGE_DELETE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SLIRD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slird check failed");
`define SLIRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slird check failed");
`else
`define SLIRD_ASSERT_IMP(lbl, ante, cons)
`define SLIRD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/slird_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list unit package
// Field widths, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package slird_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int IDX_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_INS_FIRST,
        DP_INS_STEP,
        DP_INS_PUT,
        DP_DEL_FIRST,
        DP_DEL_STEP,
        DP_RD_ISSUE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_rd;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            full;
        logic            range_bad;
        logic            idx_ok;
        logic            ins_ge;
        logic            ptr_one;
        logic            del_last;
    } sts_t;

endpackage

// ===== sv/slird_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted list unit RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slird_ram #(
    parameter int WIDTH = slird_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = slird_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/slird_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted list unit datapath
// Operand and count registers, scan pointers, list RAM and result registers.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_range_delete_unit_defines.svh"

module slird_dp #(
    parameter int CAPACITY   = slird_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slird_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  slird_pkg::cmd_t                     cmd,
    output slird_pkg::sts_t                     sts,
    input  logic [slird_pkg::OP_W-1:0]          op,
    input  logic signed [slird_pkg::FIELD_W-1:0] value,
    input  logic signed [slird_pkg::FIELD_W-1:0] upper_bound,
    input  logic [slird_pkg::IDX_W-1:0]         read_index,
    output logic [slird_pkg::STATUS_W-1:0]      status,
    output logic [slird_pkg::COUNT_W-1:0]       count,
    output logic signed [slird_pkg::FIELD_W-1:0] read_value
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IW     = (CNT_W > slird_pkg::IDX_W) ? CNT_W : slird_pkg::IDX_W;

    logic [slird_pkg::OP_W-1:0]      op_reg;
    logic signed [DATA_WIDTH-1:0]    lo_reg;
    logic signed [DATA_WIDTH-1:0]    hi_reg;
    logic [slird_pkg::IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [CNT_W-1:0]                ptr_reg;
    logic [CNT_W-1:0]                ptr_next;
    logic [CNT_W-1:0]                dst_reg;
    logic [CNT_W-1:0]                dst_next;
    logic [slird_pkg::STATUS_W-1:0]  status_reg;
    logic [slird_pkg::COUNT_W-1:0]   count_out_reg;
    logic signed [slird_pkg::FIELD_W-1:0] rdval_reg;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic signed [DATA_WIDTH-1:0] entry;
    logic                         keep;

    assign entry = $signed(ram_rdata);
    assign keep  = (entry < lo_reg) || (entry > hi_reg);

    slird_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.op         = op_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CNT_W'(CAPACITY));
        sts.range_bad  = (lo_reg > hi_reg);
        sts.idx_ok     = (IW'(idx_reg) < IW'(count_reg));
        sts.ins_ge     = !(entry < lo_reg);
        sts.ptr_one    = (ptr_reg == CNT_W'(1));
        sts.del_last   = (ptr_reg == count_reg - CNT_W'(1));
    end

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = lo_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        ptr_next   = ptr_reg;
        dst_next   = dst_reg;
        count_next = count_reg;
        unique case (cmd.op)
            slird_pkg::DP_INS_FIRST:
            begin
                if (count_reg == '0)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(count_reg - CNT_W'(1));
                    ptr_next  = count_reg;
                end
            end
            slird_pkg::DP_INS_STEP:
            begin
                ram_re    = (ptr_reg > CNT_W'(1));
                ram_raddr = ADDR_W'(ptr_reg - CNT_W'(2));
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(ptr_reg);
                if (sts.ins_ge)
                begin
                    ram_wdata = entry;
                    ptr_next  = ptr_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            slird_pkg::DP_INS_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            slird_pkg::DP_DEL_FIRST:
            begin
                ram_re   = 1'b1;
                ptr_next = '0;
                dst_next = '0;
            end
            slird_pkg::DP_DEL_STEP:
            begin
                if (keep)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(dst_reg);
                    ram_wdata = entry;
                    dst_next  = dst_reg + CNT_W'(1);
                end
                ram_re    = !sts.del_last;
                ram_raddr = ADDR_W'(ptr_reg + CNT_W'(1));
                ptr_next  = ptr_reg + CNT_W'(1);
                if (sts.del_last)
                begin
                    count_next = dst_reg + CNT_W'(keep);
                end
            end
            slird_pkg::DP_RD_ISSUE:
            begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(idx_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            dst_reg   <= dst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == slird_pkg::DP_CAPTURE)
        begin
            op_reg  <= op;
            lo_reg  <= DATA_WIDTH'(value);
            hi_reg  <= DATA_WIDTH'(upper_bound);
            idx_reg <= read_index;
        end
        if (cmd.res_load)
        begin
            status_reg    <= cmd.res_status;
            count_out_reg <= slird_pkg::COUNT_W'(count_reg);
            rdval_reg     <= cmd.res_rd ? slird_pkg::FIELD_W'(entry) : '0;
        end
    end

    assign status     = status_reg;
    assign count      = count_out_reg;
    assign read_value = rdval_reg;

    `SLIRD_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SLIRD_ASSERT_IMP(a_ins_ptr_nonzero, cmd.op == slird_pkg::DP_INS_STEP, ptr_reg != '0)
    `SLIRD_ASSERT_IMP(a_del_dst_behind, cmd.op == slird_pkg::DP_DEL_STEP, dst_reg <= ptr_reg)

endmodule

// ===== sv/slird_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted list unit controller
// Sequences capture, search/shift, compaction and result hand-off.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_range_delete_unit_defines.svh"

module slird_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  slird_pkg::sts_t sts,
    output slird_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_FINISH
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [slird_pkg::STATUS_W-1:0] res_status_reg;
    logic [slird_pkg::STATUS_W-1:0] res_status_next;
    logic                           res_rd_reg;
    logic                           res_rd_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd             = '0;
        cmd.op          = slird_pkg::DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = slird_pkg::DP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_status_next = slird_pkg::ST_OK;
                res_rd_next     = 1'b0;
                state_next      = S_FINISH;
                case (sts.op)
                    slird_pkg::OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            res_status_next = slird_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op = slird_pkg::DP_INS_FIRST;
                            if (!sts.count_zero)
                            begin
                                state_next = S_INS_SCAN;
                            end
                        end
                    end
                    slird_pkg::OP_DELETE:
                    begin
                        if (sts.range_bad)
                        begin
                            res_status_next = slird_pkg::ST_BAD;
                        end
                        else if (!sts.count_zero)
                        begin
                            cmd.op     = slird_pkg::DP_DEL_FIRST;
                            state_next = S_DEL_SCAN;
                        end
                    end
                    slird_pkg::OP_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.op      = slird_pkg::DP_RD_ISSUE;
                            res_rd_next = 1'b1;
                        end
                        else
                        begin
                            res_status_next = slird_pkg::ST_BAD;
                        end
                    end
                    default:
                    begin
                        res_status_next = slird_pkg::ST_BAD;
                    end
                endcase
            end
            S_INS_SCAN:
            begin
                cmd.op = slird_pkg::DP_INS_STEP;
                if (!sts.ins_ge)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.ptr_one)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.op     = slird_pkg::DP_INS_PUT;
                state_next = S_FINISH;
            end
            S_DEL_SCAN:
            begin
                cmd.op = slird_pkg::DP_DEL_STEP;
                if (sts.del_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = res_status_reg;
                    cmd.res_rd     = res_rd_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= slird_pkg::ST_OK;
            res_rd_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_rd_reg     <= res_rd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    `SLIRD_ASSERT_NEXT(a_finish_delivers, (state_reg == S_FINISH) && (!out_valid_reg || out_ready), out_valid_reg)
    `SLIRD_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
    `SLIRD_ASSERT_NEXT(a_insert_stops, (state_reg == S_INS_SCAN) && !sts.ins_ge, state_reg == S_FINISH)

endmodule

// ===== sv/sorted_list_insert_range_delete_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted list unit with ordered insert and range delete
// Ascending list of signed values in one RAM with an entry count; insert,
// range delete and indexed read, one result per item.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   op, value, upper_bound, read_index
//  out      out_valid / out_ready status, count, read_value
//
//  One item at a time. Insert into an empty list writes at once, otherwise
//  it shifts each entry not less than the value up one place and then
//  writes; range delete walks every entry. The single RAM read port walks
//  one entry per cycle during search, shift and compaction. Reset clears
//  the entry count and scan pointers only; no clearing pass. A result
//  held by out_ready low does not block intake of the next item; that
//  item's result waits until the held one is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_range_delete_unit #(
    parameter int CAPACITY   = slird_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = slird_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [slird_pkg::OP_W-1:0]           op,
    input  logic signed [slird_pkg::FIELD_W-1:0] value,
    input  logic signed [slird_pkg::FIELD_W-1:0] upper_bound,
    input  logic [slird_pkg::IDX_W-1:0]          read_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [slird_pkg::STATUS_W-1:0]       status,
    output logic [slird_pkg::COUNT_W-1:0]        count,
    output logic signed [slird_pkg::FIELD_W-1:0] read_value
);

    slird_pkg::cmd_t cmd;
    slird_pkg::sts_t sts;

    slird_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    slird_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .value       (value),
        .upper_bound (upper_bound),
        .read_index  (read_index),
        .status      (status),
        .count       (count),
        .read_value  (read_value)
    );

endmodule

// ===== verif/list_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list result checker
// Watches both channels of the sorted list unit, keeps its own copy of the
// list, predicts the reply of every accepted item and compares each
// returned reply with the oldest one still due.
// ----------------------------------------------------------------------------
module list_result_checker
    import slird_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [OP_W-1:0]             op,
    input  logic signed [FIELD_W-1:0]   value,
    input  logic signed [FIELD_W-1:0]   upper_bound,
    input  logic [IDX_W-1:0]            read_index,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [STATUS_W-1:0]         status,
    input  logic [COUNT_W-1:0]          count,
    input  logic signed [FIELD_W-1:0]   read_value,
    output int                          err_count,
    output int                          pending
);

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [COUNT_W-1:0]         count;
        logic signed [FIELD_W-1:0]  read_value;
    } list_reply_t;

    logic signed [FIELD_W-1:0] entries [CAPACITY];
    int unsigned               n_entries = 0;
    list_reply_t               replies_due [$];
    int                        errors = 0;

    function automatic list_reply_t apply_list_op(
        input logic [OP_W-1:0]           o,
        input logic signed [FIELD_W-1:0] v,
        input logic signed [FIELD_W-1:0] hi,
        input logic [IDX_W-1:0]          ix
    );
        list_reply_t               r;
        int unsigned               pos;
        int unsigned               k;
        int unsigned               dst;
        logic signed [FIELD_W-1:0] e;
        r.status     = ST_OK;
        r.read_value = '0;
        if (o == OP_INSERT)
        begin
            if (n_entries >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < n_entries && entries[pos] < v)
                    pos++;
                for (k = n_entries; k > pos; k--)
                    entries[k] = entries[k-1];
                entries[pos] = v;
                n_entries++;
            end
        end
        else if (o == OP_DELETE)
        begin
            if (v > hi)
                r.status = ST_BAD;
            else
            begin
                dst = 0;
                for (k = 0; k < n_entries; k++)
                begin
                    e = entries[k];
                    if (e < v || e > hi)
                    begin
                        entries[dst] = e;
                        dst++;
                    end
                end
                n_entries = dst;
            end
        end
        else if (o == OP_READ)
        begin
            if (ix < n_entries)
                r.read_value = entries[ix];
            else
                r.status = ST_BAD;
        end
        else
            r.status = ST_BAD;
        r.count = n_entries[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t want;
        if (!rst_n)
        begin
            n_entries = 0;
            replies_due.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                replies_due.push_back(apply_list_op(op, value, upper_bound, read_index));
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                    report_mismatch("reply with no item outstanding");
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  status, want.status));
                    if (count !== want.count)
                        report_mismatch($sformatf("count got %0d exp %0d",
                                                  count, want.count));
                    if (read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %0d exp %0d",
                                                  read_value, want.read_value));
                end
            end
        end
        pending   <= replies_due.size();
        err_count <= errors;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list unit testbench
// Drives directed and random insert, range delete, read and unused items
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import slird_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic signed [FIELD_W-1:0] V_MAX = 32'sh7fffffff;
    localparam logic signed [FIELD_W-1:0] V_MIN = 32'sh80000000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [OP_W-1:0]            op;
    logic signed [FIELD_W-1:0]  value;
    logic signed [FIELD_W-1:0]  upper_bound;
    logic [IDX_W-1:0]           read_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;
    logic signed [FIELD_W-1:0]  read_value;
    int                         err_count;
    int                         pending;
    int                         idle_cycles;
    bit                         no_idle;

    sorted_list_insert_range_delete_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .value       (value),
        .upper_bound (upper_bound),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .count       (count),
        .read_value  (read_value)
    );

    list_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .value       (value),
        .upper_bound (upper_bound),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .count       (count),
        .read_value  (read_value),
        .err_count   (err_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 40) - 20;
        if (r < 70)
            return $urandom_range(0, 2000) - 1000;
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return V_MIN;
            1: return V_MIN + 1;
            2: return V_MAX;
            3: return V_MAX - 1;
            4: return 0;
            default: return -1;
        endcase
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]           o,
        input logic signed [FIELD_W-1:0] v,
        input logic signed [FIELD_W-1:0] hi,
        input logic [IDX_W-1:0]          ix
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        value       <= v;
        upper_bound <= hi;
        read_index  <= ix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_item(input bit filling);
        int                        r;
        int                        s;
        longint                    t;
        logic [OP_W-1:0]           o;
        logic signed [FIELD_W-1:0] v;
        logic signed [FIELD_W-1:0] hi;
        logic [IDX_W-1:0]          ix;
        r  = $urandom_range(0, 99);
        v  = pick_value();
        hi = $urandom;
        ix = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63))
                                         : IDX_W'($urandom_range(0, 15));
        if (filling)
            o = (r < 85) ? OP_INSERT : (r < 90) ? OP_DELETE : (r < 97) ? OP_READ : OP_UNUSED;
        else
            o = (r < 30) ? OP_INSERT : (r < 60) ? OP_DELETE : (r < 95) ? OP_READ : OP_UNUSED;
        if (o == OP_DELETE)
        begin
            s = $urandom_range(0, 9);
            if (s < 6)
            begin
                t = longint'(v) + longint'($urandom_range(0, filling ? 3 : 40));
                if (t > longint'(V_MAX))
                    t = longint'(V_MAX);
                hi = t[FIELD_W-1:0];
            end
            else if (s < 8)
                hi = v;
            else
                hi = pick_value();
        end
        send_item(o, v, hi, ix);
    endtask

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        bit filling;
        in_valid    <= 1'b0;
        op          <= OP_INSERT;
        value       <= '0;
        upper_bound <= '0;
        read_index  <= '0;
        out_ready   <= 1'b0;
        rst_n       <= 1'b0;
        no_idle     = 1'b0;
        filling     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_READ,   0, 0, 0);
        send_item(OP_UNUSED, 0, 0, 0);
        send_item(OP_DELETE, V_MIN, V_MAX, 0);
        send_item(OP_INSERT, V_MAX, 0, 0);
        send_item(OP_INSERT, V_MIN, 0, 0);
        send_item(OP_INSERT, 0, 0, 0);
        send_item(OP_INSERT, 0, 0, 0);
        send_item(OP_INSERT, -1, 0, 0);
        send_item(OP_INSERT, 1, 0, 0);
        send_item(OP_READ,   0, 0, 0);
        send_item(OP_READ,   0, 0, 5);
        send_item(OP_READ,   0, 0, 6);
        send_item(OP_READ,   0, 0, 63);
        send_item(OP_DELETE, 5, 4, 0);
        send_item(OP_DELETE, 100, 200, 0);
        send_item(OP_DELETE, 0, 0, 0);
        send_item(OP_DELETE, V_MIN, V_MIN, 0);
        send_item(OP_DELETE, V_MAX, V_MAX, 0);
        send_item(OP_UNUSED, -1, -1, 63);
        send_item(OP_READ,   0, 0, 0);
        send_item(OP_INSERT, -1, 0, 0);
        send_item(OP_DELETE, V_MIN, V_MAX, 0);
        send_item(OP_READ,   0, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                filling = ~filling;
            no_idle = ((i / 50) % 4 == 3);
            send_random_item(filling);
        end
        in_valid <= 1'b0;
        no_idle  = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/slird_pkg.sv
sv/slird_ram.sv
sv/slird_dp.sv
sv/slird_ctrl.sv
sv/sorted_list_insert_range_delete_unit.sv
verif/list_result_checker.sv
verif/tb_top.sv
